FILE: sv/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types, codes and constants for the sorted list insert/remove core.
// ----------------------------------------------------------------------------
package sli_pkg;

  // Default number of entries the list can hold.
  localparam int DEFAULT_CAPACITY = 16;

  // Fixed field widths.
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Request and response items.
  typedef struct packed {
    logic                      opcode;
    logic signed [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] echoed_value;
    logic [COUNT_W-1:0]        count_after;
  } rsp_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_CHECK,
    S_INS_EVAL,
    S_SCAN_CHECK,
    S_SCAN_EVAL,
    S_DEL_CHECK,
    S_DEL_EVAL,
    S_FINISH
  } state_e;

  // Read address selection relative to the walk index.
  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_value;
    logic    idx_inc;
    logic    idx_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_end;
    logic next_at_end;
    logic rd_less;
    logic rd_equal;
  } stat_t;

endpackage

FILE: sv/sorted_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core
// Keeps up to CAPACITY signed values in ascending order; each item inserts or
// removes one value and yields one response with status, value and count.
// ----------------------------------------------------------------------------
// Walk: after accept, the response waits on the walk over the n entries of the RAM:
//   none when full or empty; a remove reads all n entries on a match or a miss past the end,
//   and reads up to the first larger one on other misses; an insert shifts each larger entry
//   up and reads the first smaller one (none when the value becomes the new head).
//   Throughput: one item at a time; an item is taken while the last response still waits.
// Reset clears the count, control and response valid; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_core import sli_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and compare logic.
  sli_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule

FILE: sv/sli_ram.sv
// ----------------------------------------------------------------------------
// sli_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/sli_dp.sv
// ----------------------------------------------------------------------------
// sli_dp
// Datapath: latched item, walk index, entry count, entry RAM and the
// response register.
// ----------------------------------------------------------------------------
module sli_dp import sli_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output rsp_t  rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] CAP_IW = IW'(CAPACITY);
  localparam logic [IW-1:0] ONE_IW = IW'(1);

  logic                      op;
  logic signed [VALUE_W-1:0] value;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             count;
  logic [IW-1:0]             rd_idx;
  logic [VALUE_W-1:0]        rd_data;
  logic [VALUE_W-1:0]        wr_data;

  // Latched item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req.opcode;
      value <= req.item_value;
    end
  end

  // Walk index: removes scan upward from the head, inserts walk down from the tail.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= req.opcode ? '0 : count;
    end else if (cmd.idx_inc) begin
      idx <= idx + ONE_IW;
    end else if (cmd.idx_dec) begin
      idx <= idx - ONE_IW;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + ONE_IW;
    end else if (cmd.cnt_dec) begin
      count <= count - ONE_IW;
    end
  end

  // Read address next to the walk index.
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_idx = idx - ONE_IW;
      RD_CUR:  rd_idx = idx;
      RD_NEXT: rd_idx = idx + ONE_IW;
      default: rd_idx = idx;
    endcase
  end

  assign wr_data = cmd.wr_value ? value : rd_data;

  sli_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(idx[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  // Status toward the controller.
  always_comb begin
    stat.is_remove   = (op == OP_REMOVE);
    stat.full        = (count == CAP_IW);
    stat.empty       = (count == '0);
    stat.idx_zero    = (idx == '0);
    stat.idx_at_end  = (idx == count);
    stat.next_at_end = ((idx + ONE_IW) == count);
    stat.rd_less     = ($signed(rd_data) < value);
    stat.rd_equal    = ($signed(rd_data) == value);
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.status       <= cmd.res_status;
      rsp.echoed_value <= value;
      rsp.count_after  <= COUNT_W'(count);
    end
  end

endmodule

FILE: sv/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// Controller: sequences the search and shift walks over the entry RAM and
// runs both handshakes.
// ----------------------------------------------------------------------------
module sli_ctrl import sli_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_e  state, state_next;
  status_e code, code_next;
  logic    rsp_valid_next;

  // State, result code and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    code_next      = code;
    cmd            = '0;
    cmd.rd_sel     = RD_CUR;
    cmd.res_status = code;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;

    case (state)
      // No item is taken while reset is held.
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end

      // Screen out the full and empty cases.
      S_START: begin
        if (!stat.is_remove) begin
          if (stat.full) begin
            code_next  = ST_FULL;
            state_next = S_FINISH;
          end else begin
            state_next = S_INS_CHECK;
          end
        end else begin
          if (stat.empty) begin
            code_next  = ST_EMPTY;
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN_CHECK;
          end
        end
      end

      // Insert: place the value at the head or read the entry below.
      S_INS_CHECK: begin
        if (stat.idx_zero) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          code_next    = ST_OK;
          state_next   = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_EVAL;
        end
      end

      // Insert: a smaller entry stops the walk, others move up one place.
      S_INS_EVAL: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_less) begin
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          code_next    = ST_OK;
          state_next   = S_FINISH;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_INS_CHECK;
        end
      end

      // Remove: scan for the first entry not smaller than the value.
      S_SCAN_CHECK: begin
        if (stat.idx_at_end) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_SCAN_EVAL;
        end
      end

      S_SCAN_EVAL: begin
        if (stat.rd_less) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_CHECK;
        end else if (stat.rd_equal) begin
          state_next = S_DEL_CHECK;
        end else begin
          code_next  = ST_NOT_FOUND;
          state_next = S_FINISH;
        end
      end

      // Remove: pull the entries above the match down one place.
      S_DEL_CHECK: begin
        if (stat.next_at_end) begin
          cmd.cnt_dec = 1'b1;
          code_next   = ST_OK;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_DEL_EVAL;
        end
      end

      S_DEL_EVAL: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_DEL_CHECK;
      end

      // Hand the result to the response register once it is free.
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.res_load   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
